// ----- src/bsle_pkg.sv -----
// Shared types and constants for the bounded sequential list engine.
// No dependencies; imported by the interfaces and every module of the block.
`default_nettype none

package bsle_pkg;

  localparam int KEY_W  = 32;
  localparam int OP_W   = 3;
  localparam int POS_W  = 7;
  localparam int STAT_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT  = 3'd0,
    OP_INS_POS    = 3'd1,
    OP_INS_SORTED = 3'd2,
    OP_FIND_LIN   = 3'd3,
    OP_FIND_BIN   = 3'd4,
    OP_DELETE     = 3'd5
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK       = 3'd0,
    STATUS_FULL     = 3'd1,
    STATUS_BADPOS   = 3'd2,
    STATUS_NOTFOUND = 3'd3,
    STATUS_DUP      = 3'd4,
    STATUS_EMPTY    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- src/bsle_if.sv -----
// Request and response channel interfaces of the list engine.
// Depends on bsle_pkg for the field widths.
`default_nettype none

interface bsle_req_if;
  import bsle_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [KEY_W-1:0]  key;
  logic [POS_W-1:0]  position;

  modport source (output valid, output operation, output key, output position,
                  input ready);
  modport sink   (input valid, input operation, input key, input position,
                  output ready);
endinterface

interface bsle_rsp_if;
  import bsle_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [POS_W-1:0]  found_position;
  logic [POS_W-1:0]  entry_count;

  modport source (output valid, output status, output found_position,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input found_position,
                  input entry_count, output ready);
endinterface

`default_nettype wire

// ----- src/bsle_cell.sv -----
// One storage cell of the list ring: a key register loaded from its neighbor.
// Depends on bsle_pkg for the key width.
`default_nettype none

module bsle_cell (
  input  logic                      clk,
  input  logic                      shift,
  input  logic [bsle_pkg::KEY_W-1:0] d,
  output logic [bsle_pkg::KEY_W-1:0] q
);
  import bsle_pkg::*;

  logic [KEY_W-1:0] key_q;

  always_ff @(posedge clk) begin
    if (shift) begin
      key_q <= d;
    end
  end

  assign q = key_q;

endmodule

`default_nettype wire

// ----- src/bounded_sequential_list_engine_core.sv -----
// List engine top level: a ring of CAPACITY cells rotated past the controller taps at cells 0 and 1.
// Rejected requests skip the ring; other requests take one ring pass; binary find takes
// further passes until the key is found or the range is empty, at least one probe per pass.
// Throughput: one request at a time, set by the ring rotation; a result may wait in
// the output register while the next request runs. Reset clears the count and control; cell
// contents are undefined until written and need no clearing pass.
`default_nettype none

module bounded_sequential_list_engine_core #(
  parameter int CAPACITY = 64
) (
  input  logic           clk,
  input  logic           rst,
  bsle_req_if.sink       req,
  bsle_rsp_if.source     rsp
);
  import bsle_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int EW    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam logic [IDX_W-1:0] LAST     = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  state_t            state, state_next;
  op_t               op;
  op_t               req_op;
  logic [KEY_W-1:0]  key_r;
  logic [POS_W-1:0]  pos_r;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  t, t_next;
  logic [KEY_W-1:0]  carry;
  logic              ins_active, del_active, resolved;
  logic [CNT_W-1:0]  lo, hi, mid;
  status_t           res_status;
  logic [CNT_W-1:0]  res_found;
  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic [POS_W-1:0]  out_found, out_count;

  logic              accept, shift, run_end, out_load;
  logic              pre_done;
  status_t           pre_status, start_status;
  logic [CNT_W-1:0]  start_found, hit_pos;
  logic [EW-1:0]     cnt_e, rpos_e, t_e, pos_m1;
  logic              in_list, key_eq, key_gt;
  logic              ins_trig, del_trig, dup_hit, lin_hit, bin_probe;
  logic [KEY_W-1:0]  tap0, tap1, wb;
  logic [KEY_W-1:0]  cell_q [CAPACITY];

  // Ring of cells: each takes its upper neighbor, the tail takes the write-back value.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0] d;
    if (i == CAPACITY - 1) begin : g_tail
      assign d = wb;
    end else begin : g_body
      assign d = cell_q[i+1];
    end
    bsle_cell u_cell (
      .clk   (clk),
      .shift (shift),
      .d     (d),
      .q     (cell_q[i])
    );
  end

  assign tap0   = cell_q[0];
  assign tap1   = cell_q[1];
  assign req_op = op_t'(req.operation);
  assign accept = req.valid && req.ready;

  // Check the request against the current fill before any pass.
  always_comb begin
    cnt_e        = EW'(count);
    rpos_e       = EW'(req.position);
    pre_done     = 1'b0;
    pre_status   = STATUS_OK;
    start_status = STATUS_OK;
    start_found  = '0;
    case (req_op)
      OP_INS_FRONT: begin
        start_found = CNT_W'(1);
        if (count == FULL_CNT) begin
          pre_done   = 1'b1;
          pre_status = STATUS_FULL;
        end
      end
      OP_INS_POS: begin
        start_found = CNT_W'(req.position);
        if (count == FULL_CNT) begin
          pre_done   = 1'b1;
          pre_status = STATUS_FULL;
        end else if (rpos_e == '0 || rpos_e > cnt_e + EW'(1)) begin
          pre_done   = 1'b1;
          pre_status = STATUS_BADPOS;
        end
      end
      OP_INS_SORTED: begin
        if (count == FULL_CNT) begin
          pre_done   = 1'b1;
          pre_status = STATUS_FULL;
        end
      end
      OP_FIND_LIN, OP_FIND_BIN: begin
        start_status = STATUS_NOTFOUND;
      end
      OP_DELETE: begin
        start_found = CNT_W'(req.position);
        if (count == '0) begin
          pre_done   = 1'b1;
          pre_status = STATUS_EMPTY;
        end else if (rpos_e == '0 || rpos_e > cnt_e) begin
          pre_done   = 1'b1;
          pre_status = STATUS_BADPOS;
        end
      end
      default: begin
        pre_done   = 1'b1;
        pre_status = STATUS_OK;
      end
    endcase
  end

  // Per-cycle decisions at the ring tap.
  always_comb begin
    t_e       = EW'(t);
    pos_m1    = EW'(pos_r) - EW'(1);
    in_list   = t_e < cnt_e;
    key_eq    = tap0 == key_r;
    key_gt    = $signed(key_r) > $signed(tap0);
    hit_pos   = CNT_W'(t) + CNT_W'(1);
    mid       = lo + ((hi - lo) >> 1);
    ins_trig  = 1'b0;
    dup_hit   = 1'b0;
    lin_hit   = 1'b0;
    bin_probe = 1'b0;
    del_trig  = 1'b0;
    case (op)
      OP_INS_FRONT:  ins_trig = !ins_active && t == '0;
      OP_INS_POS:    ins_trig = !ins_active && t_e == pos_m1;
      OP_INS_SORTED: begin
        dup_hit  = !resolved && in_list && key_eq;
        ins_trig = !resolved && !dup_hit && ((t_e == cnt_e) || (in_list && !key_gt));
      end
      OP_FIND_LIN:   lin_hit = !resolved && in_list && key_eq;
      OP_FIND_BIN:   bin_probe = !resolved && lo < hi && EW'(t) == EW'(mid);
      OP_DELETE:     del_trig = t_e == pos_m1;
      default:       ins_trig = 1'b0;
    endcase
    if (ins_active) begin
      wb = carry;
    end else if (ins_trig) begin
      wb = key_r;
    end else if (del_active || del_trig) begin
      wb = tap1;
    end else begin
      wb = tap0;
    end
    t_next  = (t == LAST) ? '0 : t + IDX_W'(1);
    run_end = t == LAST && (op != OP_FIND_BIN || resolved || !(lo < hi));
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) state_next = pre_done ? S_DONE : S_RUN;
      S_RUN:  if (run_end) state_next = S_DONE;
      S_DONE: if (!out_valid || rsp.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready = state == S_IDLE;
    shift     = state == S_RUN;
    out_load  = state == S_DONE && (!out_valid || rsp.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      t          <= '0;
      ins_active <= 1'b0;
      del_active <= 1'b0;
      resolved   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        t          <= '0;
        ins_active <= 1'b0;
        del_active <= 1'b0;
        resolved   <= 1'b0;
      end else if (shift) begin
        t          <= t_next;
        ins_active <= ins_active | ins_trig;
        del_active <= del_active | del_trig;
        if (dup_hit || lin_hit || (bin_probe && key_eq) ||
            (ins_trig && op == OP_INS_SORTED)) begin
          resolved <= 1'b1;
        end
        if (run_end) begin
          if (ins_active || ins_trig) begin
            count <= count + CNT_W'(1);
          end else if (op == OP_DELETE) begin
            count <= count - CNT_W'(1);
          end
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op         <= req_op;
      key_r      <= req.key;
      pos_r      <= req.position;
      lo         <= '0;
      hi         <= count;
      res_status <= pre_done ? pre_status : start_status;
      res_found  <= pre_done ? '0 : start_found;
    end else if (shift) begin
      if (ins_active || ins_trig) begin
        carry <= tap0;
      end
      if (dup_hit) begin
        res_status <= STATUS_DUP;
        res_found  <= hit_pos;
      end else if (ins_trig && op == OP_INS_SORTED) begin
        res_found <= hit_pos;
      end
      if (lin_hit || (bin_probe && key_eq)) begin
        res_status <= STATUS_OK;
        res_found  <= hit_pos;
      end
      if (bin_probe && !key_eq) begin
        if (key_gt) begin
          lo <= mid + CNT_W'(1);
        end else begin
          hi <= mid;
        end
      end
    end
    if (out_load) begin
      out_status <= res_status;
      out_found  <= POS_W'(res_found);
      out_count  <= POS_W'(count);
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.found_position = out_found;
  assign rsp.entry_count    = out_count;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("fill count above capacity");

  a_ring_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && t != LAST) |=> (t == $past(t) + IDX_W'(1)))
    else $error("ring phase skipped a cell");

  a_shift_excl: assert property (@(posedge clk) disable iff (rst)
    !(ins_active && del_active))
    else $error("insert and delete shift active together");

  a_bin_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && op == OP_FIND_BIN && !resolved) |-> (lo <= hi && hi <= count))
    else $error("binary search range outside the list");

endmodule

`default_nettype wire
